/* hdl/gmad_pkg.sv */
package gmad_pkg;

  localparam int SampleW       = 16;
  localparam int SumW          = 20;
  localparam int CountW        = 4;
  localparam int WindowDefault = 2;
  localparam int WindowMax     = 16;
  localparam int RecipW        = SumW + 1;
  localparam int ProdW         = SumW + RecipW;
  localparam int PipeDepth     = 3;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [SumW-1:0]    total_t;

  typedef struct packed {
    sample_t x;
    sample_t y;
    sample_t z;
  } axes_t;

  typedef struct packed {
    total_t x;
    total_t y;
    total_t z;
  } totals_t;

  function automatic total_t widen(input sample_t v);
    widen = SumW'(v);
  endfunction

endpackage

/* hdl/gmad_if.sv */
interface gmad_in_if;
  import gmad_pkg::*;

  logic    valid;
  logic    ready;
  sample_t axis_x;
  sample_t axis_y;
  sample_t axis_z;
  logic    read_ok;

  modport source (output valid, output axis_x, output axis_y, output axis_z,
                  output read_ok, input ready);
  modport sink   (input valid, input axis_x, input axis_y, input axis_z,
                  input read_ok, output ready);
endinterface

interface gmad_out_if;
  import gmad_pkg::*;

  logic    valid;
  logic    ready;
  sample_t avg_x;
  sample_t avg_y;
  sample_t avg_z;
  logic    window_full;
  logic    output_ready;

  modport source (output valid, output avg_x, output avg_y, output avg_z,
                  output window_full, output output_ready, input ready);
  modport sink   (input valid, input avg_x, input avg_y, input avg_z,
                  input window_full, input output_ready, output ready);
endinterface

/* hdl/gmad_mean_div.sv */
module gmad_mean_div #(
  parameter int WINDOW = gmad_pkg::WindowDefault
) (
  input  gmad_pkg::total_t  total,
  input  logic              use_mean,
  output gmad_pkg::sample_t mean
);
  import gmad_pkg::*;

  localparam int             LogW   = $clog2(WINDOW);
  localparam int             Shift  = SumW + LogW;
  localparam longint         RecipL = ((longint'(1) << Shift) + longint'(WINDOW) - 1)
                                      / longint'(WINDOW);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);

  logic              neg;
  logic [SumW-1:0]   mag;
  logic [ProdW-1:0]  prod;
  logic [SampleW:0]  quot;
  logic [SampleW:0]  signed_quot;

  always_comb begin
    neg         = total[SumW-1];
    mag         = neg ? SumW'(-total) : SumW'(total);
    prod        = ProdW'(mag) * ProdW'(Recip);
    quot        = prod[Shift +: SampleW+1];
    signed_quot = neg ? (SampleW+1)'(-quot) : quot;
    mean        = use_mean ? sample_t'(signed_quot[SampleW-1:0])
                           : sample_t'(total[SampleW-1:0]);
  end

endmodule

/* hdl/gyro_moving_average_decimator_core.sv */
// Three-axis boxcar moving average over the last WINDOW good gyro samples with
// a decimated data-ready strobe. Every input word yields exactly one result word,
// in order. A word with read_ok low leaves the window and totals untouched but
// still advances the decimation counter; output_ready is high on every
// WINDOW-th word. Until the window has wrapped once the raw sample passes
// through; after that each axis reads total / WINDOW, truncated toward zero.
// The block takes one word per cycle while the output is not stalled. A result
// passes three registers after its word is accepted: an input register, the
// window/total update, and the constant-reciprocal divide into the output
// register. All three stages stall independently, so a held result does not
// block new input while earlier stages have room. Window stores and totals
// clear on reset.
module gyro_moving_average_decimator_core #(
  parameter int WINDOW = gmad_pkg::WindowDefault
) (
  input logic          clk,
  input logic          rst,
  gmad_in_if.sink      gyro,
  gmad_out_if.source   avg
);
  import gmad_pkg::*;

  localparam int                SlotW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [SlotW-1:0]  LastSlot  = SlotW'(WINDOW - 1);
  localparam logic [CountW-1:0] LastCount = CountW'(WINDOW - 1);
  localparam logic              UseStore  = (WINDOW > 1);

  // input register
  logic    s1_valid;
  axes_t   s1_sample;
  logic    s1_ok;

  // update stage register
  logic    s2_valid;
  totals_t s2_value;
  logic    s2_mean;
  logic    s2_full;
  logic    s2_strobe;

  // output register
  logic    o_valid;
  axes_t   o_avg;
  logic    o_full;
  logic    o_strobe;

  // window state
  axes_t             win [WINDOW];
  totals_t           sum;
  logic [SlotW-1:0]  slot;
  logic              filled;
  logic [CountW-1:0] count;

  logic              out_free, s2_free, s1_free;
  logic              s1_move, s2_move;
  axes_t             old;
  logic              upd;
  totals_t           sum_next;
  totals_t           sum_after;
  logic [SlotW-1:0]  slot_next;
  logic              filled_next;
  logic              strobe;
  logic [CountW-1:0] count_next;
  axes_t             mean;

  assign out_free   = !o_valid || avg.ready;
  assign s2_free    = !s2_valid || out_free;
  assign s1_free    = !s1_valid || s2_free;
  assign s2_move    = s2_valid && out_free;
  assign s1_move    = s1_valid && s2_free;
  assign gyro.ready = s1_free;

  always_comb begin
    old        = win[slot];
    upd        = UseStore && s1_ok;
    sum_next.x = sum.x - widen(old.x) + widen(s1_sample.x);
    sum_next.y = sum.y - widen(old.y) + widen(s1_sample.y);
    sum_next.z = sum.z - widen(old.z) + widen(s1_sample.z);
    sum_after  = upd ? sum_next : sum;
    slot_next  = (slot == LastSlot) ? '0 : slot + SlotW'(1);
    filled_next = filled || (upd && slot == LastSlot);
    strobe     = (count == LastCount);
    count_next = strobe ? '0 : count + CountW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      o_valid  <= 1'b0;
      sum      <= '0;
      slot     <= '0;
      filled   <= 1'b0;
      count    <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (s1_free) begin
        s1_valid <= gyro.valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        o_valid <= s2_valid;
      end
      if (s1_move) begin
        count <= count_next;
        if (upd) begin
          win[slot] <= s1_sample;
          sum       <= sum_next;
          slot      <= slot_next;
          filled    <= filled_next;
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (gyro.valid && s1_free) begin
      s1_sample.x <= gyro.axis_x;
      s1_sample.y <= gyro.axis_y;
      s1_sample.z <= gyro.axis_z;
      s1_ok       <= gyro.read_ok;
    end
    if (s1_move) begin
      s2_mean   <= UseStore && filled_next;
      s2_full   <= filled_next;
      s2_strobe <= strobe;
      if (UseStore && filled_next) begin
        s2_value <= sum_after;
      end else begin
        s2_value.x <= widen(s1_sample.x);
        s2_value.y <= widen(s1_sample.y);
        s2_value.z <= widen(s1_sample.z);
      end
    end
    if (s2_move) begin
      o_avg    <= mean;
      o_full   <= s2_full;
      o_strobe <= s2_strobe;
    end
  end

  gmad_mean_div #(.WINDOW(WINDOW)) u_div_x (
    .total(s2_value.x), .use_mean(s2_mean), .mean(mean.x)
  );
  gmad_mean_div #(.WINDOW(WINDOW)) u_div_y (
    .total(s2_value.y), .use_mean(s2_mean), .mean(mean.y)
  );
  gmad_mean_div #(.WINDOW(WINDOW)) u_div_z (
    .total(s2_value.z), .use_mean(s2_mean), .mean(mean.z)
  );

  assign avg.valid        = o_valid;
  assign avg.avg_x        = o_avg.x;
  assign avg.avg_y        = o_avg.y;
  assign avg.avg_z        = o_avg.z;
  assign avg.window_full  = o_full;
  assign avg.output_ready = o_strobe;

endmodule

/* hdl/gmad_checker.sv */
module gmad_checker #(
  parameter int WINDOW = gmad_pkg::WindowDefault
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input gmad_pkg::sample_t avg_x,
  input gmad_pkg::sample_t avg_y,
  input gmad_pkg::sample_t avg_z,
  input logic              window_full,
  input logic              output_ready
);
  import gmad_pkg::*;

  localparam logic [CountW-1:0] LastCount = CountW'(WINDOW - 1);
  localparam int                FlightW   = $clog2(PipeDepth + 2);
  localparam logic [FlightW-1:0] MaxFlight = FlightW'(PipeDepth);

  logic               in_acc, out_acc;
  logic [FlightW-1:0] flight;
  logic [CountW-1:0]  out_count;
  logic               seen_full;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      flight    <= '0;
      out_count <= '0;
      seen_full <= 1'b0;
    end else begin
      flight <= flight + FlightW'(in_acc) - FlightW'(out_acc);
      if (out_acc) begin
        out_count <= (out_count == LastCount) ? '0 : out_count + CountW'(1);
        if (window_full) begin
          seen_full <= 1'b1;
        end
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(avg_x) && $stable(avg_y)
      && $stable(avg_z) && $stable(window_full) && $stable(output_ready))
    else $error("result word changed while stalled");

  a_flight_bound: assert property (@(posedge clk) disable iff (rst)
    flight <= MaxFlight)
    else $error("more words in flight than pipeline stages");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> flight != '0)
    else $error("result word with no accepted input");

  a_decimate: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> output_ready == (out_count == LastCount))
    else $error("output_ready off its decimation slot");

  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    out_acc && seen_full |-> window_full)
    else $error("window_full dropped after being set");

endmodule

bind gyro_moving_average_decimator_core gmad_checker #(.WINDOW(WINDOW)) u_gmad_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (gyro.valid),
  .in_ready     (gyro.ready),
  .out_valid    (avg.valid),
  .out_ready    (avg.ready),
  .avg_x        (avg.avg_x),
  .avg_y        (avg.avg_y),
  .avg_z        (avg.avg_z),
  .window_full  (avg.window_full),
  .output_ready (avg.output_ready)
);

/* verif/tb_top.sv */
module tb_top;
  import gmad_pkg::*;

  localparam int Win       = WindowDefault;
  localparam int LongHold  = 400;
  localparam int IdleLimit = 4000;
  localparam int PrintCap  = 40;

  typedef struct {
    sample_t x;
    sample_t y;
    sample_t z;
    logic    ok;
  } gyro_word_t;

  typedef struct {
    sample_t x;
    sample_t y;
    sample_t z;
    logic    full;
    logic    strobe;
  } mean_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gmad_in_if  gyro_if ();
  gmad_out_if avg_if ();

  gyro_moving_average_decimator_core #(
    .WINDOW(Win)
  ) uut (
    .clk (clk),
    .rst (rst),
    .gyro(gyro_if),
    .avg (avg_if)
  );

  always #6 clk = ~clk;

  gyro_word_t queued_samples[$];
  mean_word_t pending_means[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_req     = 1'b0;
  logic hold_seen    = 1'b0;
  int hold_left      = 0;
  int idle_cycles    = 0;

  int errors       = 0;
  int words_in     = 0;
  int words_out    = 0;
  int failed_reads = 0;
  int strobes      = 0;
  int backed_up    = 0;

  // predictor state
  sample_t hist_x[Win];
  sample_t hist_y[Win];
  sample_t hist_z[Win];
  int      tot_x = 0;
  int      tot_y = 0;
  int      tot_z = 0;
  int      slot  = 0;
  int      nevents = 0;
  logic    full  = 1'b0;

  initial begin
    for (int i = 0; i < Win; i++) begin
      hist_x[i] = '0;
      hist_y[i] = '0;
      hist_z[i] = '0;
    end
    gyro_if.valid   = 1'b0;
    gyro_if.axis_x  = '0;
    gyro_if.axis_y  = '0;
    gyro_if.axis_z  = '0;
    gyro_if.read_ok = 1'b0;
    avg_if.ready    = 1'b0;
  end

  function automatic mean_word_t predict_mean(gyro_word_t w);
    mean_word_t r;
    r.x = w.x;
    r.y = w.y;
    r.z = w.z;
    if (Win > 1 && w.ok) begin
      tot_x = tot_x - int'(hist_x[slot]) + int'(w.x);
      tot_y = tot_y - int'(hist_y[slot]) + int'(w.y);
      tot_z = tot_z - int'(hist_z[slot]) + int'(w.z);
      hist_x[slot] = w.x;
      hist_y[slot] = w.y;
      hist_z[slot] = w.z;
      slot++;
      if (slot >= Win) begin
        slot = 0;
        full = 1'b1;
      end
    end
    if (Win > 1 && full) begin
      r.x = sample_t'(tot_x / Win);
      r.y = sample_t'(tot_y / Win);
      r.z = sample_t'(tot_z / Win);
    end
    nevents++;
    r.strobe = (nevents >= Win);
    if (r.strobe) nevents = 0;
    r.full = full;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= PrintCap) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  function automatic sample_t random_axis();
    case ($urandom_range(9))
      0: return sample_t'(32767);
      1: return sample_t'(-32768);
      2, 3: return sample_t'(int'($urandom_range(64)) - 32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic gyro_word_t random_gyro();
    gyro_word_t w;
    w.x  = random_axis();
    w.y  = random_axis();
    w.z  = random_axis();
    w.ok = ($urandom_range(99) < 85);
    return w;
  endfunction

  task automatic push_gyro(int x, int y, int z, logic ok);
    gyro_word_t w;
    w.x  = sample_t'(x);
    w.y  = sample_t'(y);
    w.z  = sample_t'(z);
    w.ok = ok;
    queued_samples.push_back(w);
  endtask

  task automatic wait_drained();
    while (queued_samples.size() != 0 || gyro_if.valid || pending_means.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(int s_pct, int r_pct, int n);
    @(negedge clk);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    repeat (n) queued_samples.push_back(random_gyro());
    wait_drained();
  endtask

  // driver
  always @(posedge clk) begin
    gyro_word_t accepted;
    gyro_word_t next_word;
    if (rst) begin
      gyro_if.valid <= 1'b0;
    end else begin
      if (gyro_if.valid && gyro_if.ready) begin
        accepted.x  = gyro_if.axis_x;
        accepted.y  = gyro_if.axis_y;
        accepted.z  = gyro_if.axis_z;
        accepted.ok = gyro_if.read_ok;
        pending_means.push_back(predict_mean(accepted));
        words_in++;
        if (!accepted.ok) failed_reads++;
      end
      if (!gyro_if.valid || gyro_if.ready) begin
        if (queued_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = queued_samples.pop_front();
          gyro_if.axis_x  <= next_word.x;
          gyro_if.axis_y  <= next_word.y;
          gyro_if.axis_z  <= next_word.z;
          gyro_if.read_ok <= next_word.ok;
          gyro_if.valid   <= 1'b1;
        end else begin
          gyro_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    mean_word_t want;
    if (rst) begin
      avg_if.ready <= 1'b0;
    end else begin
      if (avg_if.valid && avg_if.ready) begin
        words_out++;
        if (avg_if.output_ready) strobes++;
        if (pending_means.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: x=%0d y=%0d z=%0d",
                                    avg_if.avg_x, avg_if.avg_y, avg_if.avg_z));
        end else begin
          want = pending_means.pop_front();
          if (avg_if.avg_x !== want.x)
            report_mismatch($sformatf("word %0d avg_x got %0d want %0d",
                                      words_out, avg_if.avg_x, want.x));
          if (avg_if.avg_y !== want.y)
            report_mismatch($sformatf("word %0d avg_y got %0d want %0d",
                                      words_out, avg_if.avg_y, want.y));
          if (avg_if.avg_z !== want.z)
            report_mismatch($sformatf("word %0d avg_z got %0d want %0d",
                                      words_out, avg_if.avg_z, want.z));
          if (avg_if.window_full !== want.full)
            report_mismatch($sformatf("word %0d window_full got %b want %b",
                                      words_out, avg_if.window_full, want.full));
          if (avg_if.output_ready !== want.strobe)
            report_mismatch($sformatf("word %0d output_ready got %b want %b",
                                      words_out, avg_if.output_ready, want.strobe));
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        if (gyro_if.valid && !gyro_if.ready) backed_up++;
        avg_if.ready <= 1'b0;
      end else begin
        avg_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((gyro_if.valid && gyro_if.ready) || (avg_if.valid && avg_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout after %0d cycles with no word moving", idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    push_gyro(1234, -5, 32767, 1'b0);
    push_gyro(32767, -32768, -1, 1'b1);
    push_gyro(-32768, 32767, 1, 1'b0);
    push_gyro(32767, -32768, -2, 1'b1);
    push_gyro(32767, -32768, 0, 1'b0);
    push_gyro(-32768, 32767, 1, 1'b1);
    push_gyro(-1, -1, -1, 1'b1);
    push_gyro(0, 0, 0, 1'b1);
    push_gyro(1, -1, 3, 1'b1);
    push_gyro(-3, 3, -1, 1'b1);
    push_gyro(-32768, -32768, -32768, 1'b1);
    push_gyro(-32768, -32768, -32768, 1'b1);
    push_gyro(-32768, -32768, -32768, 1'b0);
    push_gyro(32767, 32767, 32767, 1'b1);
    push_gyro(32767, 32767, 32767, 1'b1);
    push_gyro(21845, -21846, 0, 1'b1);
    push_gyro(-21846, 21845, -1, 1'b1);
    push_gyro(100, 200, 300, 1'b0);
    push_gyro(-100, -200, -300, 1'b0);
    push_gyro(0, 0, 0, 1'b0);
    push_gyro(5, -7, 9, 1'b1);
    wait_drained();

    run_phase(0, 0, 140);
    run_phase(49, 0, 140);
    run_phase(0, 49, 140);
    run_phase(16, 16, 140);

    // backpressure: stall the output while input keeps coming
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = ~hold_req;
    repeat (60) queued_samples.push_back(random_gyro());
    wait_drained();

    repeat (4 * PipeDepth) @(posedge clk);

    $display("Covered %0d input words (%0d failed reads), %0d results, %0d strobes,",
             words_in, failed_reads, words_out, strobes);
    $display("across four idle mixes and a %0d-cycle output hold (%0d input stall cycles).",
             LongHold, backed_up);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/gmad_pkg.sv
hdl/gmad_if.sv
hdl/gmad_mean_div.sv
hdl/gyro_moving_average_decimator_core.sv
hdl/gmad_checker.sv
verif/tb_top.sv
